[hw/rtl/sfr_pkg.sv]
`default_nettype none
package sfr_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned DOOR_W    = 3;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned STORE_N   = 4;
	localparam int unsigned STORE_IDX_W = $clog2(STORE_N);

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED   = 1'd1;

	localparam logic [BYTE_W-1:0] SYNC_RESET  = 8'h55;
	localparam logic [BYTE_W-1:0] SEED_RESET  = 8'hF3;
	localparam logic [BYTE_W-1:0] CRC_POLY    = 8'h07;
	localparam logic [BYTE_W-1:0] STATUS_ADDR = 8'h00;
	localparam logic [BYTE_W-1:0] STATUS_CODE = 8'h12;

	localparam logic [DOOR_W-1:0] DOOR_OPEN    = 3'd0;
	localparam logic [DOOR_W-1:0] DOOR_CLOSED  = 3'd1;
	localparam logic [DOOR_W-1:0] DOOR_VENTING = 3'd2;
	localparam logic [DOOR_W-1:0] DOOR_OPENING = 3'd3;
	localparam logic [DOOR_W-1:0] DOOR_CLOSING = 3'd4;
	localparam logic [DOOR_W-1:0] DOOR_ERROR   = 3'd5;
	localparam logic [DOOR_W-1:0] DOOR_STOPPED = 3'd6;
	localparam logic [DOOR_W-1:0] DOOR_UNKNOWN = 3'd7;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_SKIP  = 3'd1,
		PH_DATA0 = 3'd2,
		PH_DATA1 = 3'd3,
		PH_DATA2 = 3'd4,
		PH_DATA3 = 3'd5,
		PH_CHECK = 3'd6
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte0;
		logic [BYTE_W-1:0] frame_byte1;
		logic [BYTE_W-1:0] frame_byte2;
		logic [BYTE_W-1:0] frame_byte3;
		logic              status_frame;
		logic [DOOR_W-1:0] door_state;
	} frame_t;

	typedef struct packed {
		logic   hit;
		frame_t frame;
	} parse_res_t;

	function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] c;
		c = crc ^ b;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [DOOR_W-1:0] decode_door(input logic [BYTE_W-1:0] s);
		logic [DOOR_W-1:0] d;
		priority if (s[0])            d = DOOR_OPEN;
		else if (s[1])                d = DOOR_CLOSED;
		else if (s[7])                d = DOOR_VENTING;
		else if (s[6:5] == 2'b10)     d = DOOR_OPENING;
		else if (s[6:5] == 2'b11)     d = DOOR_CLOSING;
		else if (s[4])                d = DOOR_ERROR;
		else                          d = DOOR_STOPPED;
		return d;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/sfr_if.sv]
`default_nettype none
interface sfr_rx_if;
	logic                      valid;
	logic                      ready;
	logic [sfr_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_frame_if;
	logic                       valid;
	logic                       ready;
	logic [sfr_pkg::BYTE_W-1:0] frame_byte0;
	logic [sfr_pkg::BYTE_W-1:0] frame_byte1;
	logic [sfr_pkg::BYTE_W-1:0] frame_byte2;
	logic [sfr_pkg::BYTE_W-1:0] frame_byte3;
	logic                       status_frame;
	logic [sfr_pkg::DOOR_W-1:0] door_state;

	modport source (output valid, output frame_byte0, output frame_byte1,
		output frame_byte2, output frame_byte3, output status_frame,
		output door_state, input ready);
	modport sink (input valid, input frame_byte0, input frame_byte1,
		input frame_byte2, input frame_byte3, input status_frame,
		input door_state, output ready);
endinterface
`default_nettype wire

[hw/rtl/status_frame_receiver.sv]
`default_nettype none
// channel   dir  fields                                               width
// rx        in   rx_byte                                              8
// frame     out  frame_byte0..3, status_frame, door_state             8x4, 1, 3
// cfg       in   cfg_we, cfg_index (0 sync_value, 1 crc_seed), cfg_wdata  1, 1, 8
//
// one rx beat per cycle while rx is not stalled; a good frame shows up on frame the cycle after its check byte
// the rx beat is parsed in one pass into a single result register
// rx stalls only while that result register is full and frame.ready is low
// arst_n resets the phase, crc, kept door state (unknown) and config registers
module status_frame_receiver (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	sfr_rx_if.sink                             rx,
	sfr_frame_if.source                        frame,
	input  wire logic                          cfg_we,
	input  wire logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sfr_pkg::BYTE_W-1:0]    cfg_wdata
);

	logic [sfr_pkg::BYTE_W-1:0] sync_value_q;
	logic [sfr_pkg::BYTE_W-1:0] crc_seed_q;
	logic                       out_valid_q;
	sfr_pkg::frame_t            frame_s1;
	sfr_pkg::parse_res_t        res;
	logic                       beat_en;

	assign rx.ready = !out_valid_q || frame.ready;
	assign beat_en  = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q <= sfr_pkg::SYNC_RESET;
			crc_seed_q   <= sfr_pkg::SEED_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfr_pkg::REG_SYNC_VALUE: sync_value_q <= cfg_wdata;
				sfr_pkg::REG_CRC_SEED:   crc_seed_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	sfr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_en    (beat_en),
		.rx_byte    (rx.rx_byte),
		.sync_value (sync_value_q),
		.crc_seed   (crc_seed_q),
		.res        (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (beat_en) begin
			out_valid_q <= res.hit;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_en && res.hit) begin
			frame_s1 <= res.frame;
		end
	end

	assign frame.valid        = out_valid_q;
	assign frame.frame_byte0  = frame_s1.frame_byte0;
	assign frame.frame_byte1  = frame_s1.frame_byte1;
	assign frame.frame_byte2  = frame_s1.frame_byte2;
	assign frame.frame_byte3  = frame_s1.frame_byte3;
	assign frame.status_frame = frame_s1.status_frame;
	assign frame.door_state   = frame_s1.door_state;

endmodule
`default_nettype wire

[hw/rtl/sfr_parser.sv]
`default_nettype none
module sfr_parser (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       beat_en,
	input  wire logic [sfr_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic [sfr_pkg::BYTE_W-1:0] sync_value,
	input  wire logic [sfr_pkg::BYTE_W-1:0] crc_seed,
	output sfr_pkg::parse_res_t             res
);

	sfr_pkg::phase_t            phase_q;
	sfr_pkg::phase_t            phase_d;
	logic [sfr_pkg::BYTE_W-1:0] crc_q;
	logic [sfr_pkg::BYTE_W-1:0] crc_d;
	logic [sfr_pkg::DOOR_W-1:0] door_q;
	logic [sfr_pkg::DOOR_W-1:0] door_d;
	logic [sfr_pkg::BYTE_W-1:0] store_q [sfr_pkg::STORE_N];
	logic                       store_we;
	logic [2:0]                 phase_off;
	logic [sfr_pkg::STORE_IDX_W-1:0] store_idx;
	logic                       status;

	// next phase
	always_comb begin
		unique case (phase_q)
			sfr_pkg::PH_HUNT: begin
				phase_d = (rx_byte == sync_value) ? sfr_pkg::PH_SKIP : sfr_pkg::PH_HUNT;
			end
			sfr_pkg::PH_SKIP:  phase_d = sfr_pkg::PH_DATA0;
			sfr_pkg::PH_DATA0: phase_d = sfr_pkg::PH_DATA1;
			sfr_pkg::PH_DATA1: phase_d = sfr_pkg::PH_DATA2;
			sfr_pkg::PH_DATA2: phase_d = sfr_pkg::PH_DATA3;
			sfr_pkg::PH_DATA3: phase_d = sfr_pkg::PH_CHECK;
			sfr_pkg::PH_CHECK: phase_d = sfr_pkg::PH_HUNT;
			default:           phase_d = sfr_pkg::PH_HUNT;
		endcase
	end

	assign phase_off = phase_q - sfr_pkg::PH_DATA0;
	assign store_idx = phase_off[sfr_pkg::STORE_IDX_W-1:0];
	assign status    = (store_q[0] == sfr_pkg::STATUS_ADDR) &&
		(store_q[1] == sfr_pkg::STATUS_CODE);

	// outputs of the phase machine
	always_comb begin
		crc_d    = crc_q;
		store_we = 1'b0;
		res.hit  = 1'b0;
		unique case (phase_q)
			sfr_pkg::PH_HUNT: begin
				if (rx_byte == sync_value) begin
					crc_d = crc_seed;
				end
			end
			sfr_pkg::PH_SKIP: begin
			end
			sfr_pkg::PH_DATA0, sfr_pkg::PH_DATA1,
			sfr_pkg::PH_DATA2, sfr_pkg::PH_DATA3: begin
				crc_d    = sfr_pkg::crc8_byte(crc_q, rx_byte);
				store_we = 1'b1;
			end
			sfr_pkg::PH_CHECK: begin
				res.hit = (crc_q == rx_byte);
			end
			default: begin
				if (rx_byte == sync_value) begin
					crc_d = crc_seed;
				end
			end
		endcase
		door_d = (res.hit && status) ? sfr_pkg::decode_door(store_q[2]) : door_q;
		res.frame.frame_byte0  = store_q[0];
		res.frame.frame_byte1  = store_q[1];
		res.frame.frame_byte2  = store_q[2];
		res.frame.frame_byte3  = store_q[3];
		res.frame.status_frame = status;
		res.frame.door_state   = door_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfr_pkg::PH_HUNT;
			crc_q   <= sfr_pkg::SEED_RESET;
			door_q  <= sfr_pkg::DOOR_UNKNOWN;
		end else if (beat_en) begin
			phase_q <= phase_d;
			crc_q   <= crc_d;
			door_q  <= door_d;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_en && store_we) begin
			store_q[store_idx] <= rx_byte;
		end
	end

endmodule
`default_nettype wire
